// ===== rtl/mwq_pkg.sv =====
// ----------------------------------------------------------------------------
// mwq_pkg
// Types and constants shared by the mutex with FIFO wait queue.
// ----------------------------------------------------------------------------
package mwq_pkg;

  localparam int ID_BITS     = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic REQ_LOCK   = 1'b0;
  localparam logic REQ_UNLOCK = 1'b1;

  typedef enum logic [2:0] {
    OUT_ACQUIRED      = 3'd0,
    OUT_QUEUED        = 3'd1,
    OUT_ALREADY_OWNER = 3'd2,
    OUT_NOT_RUNNING   = 3'd3,
    OUT_ALREADY_OPEN  = 3'd4,
    OUT_HANDED_OVER   = 3'd5,
    OUT_OPENED        = 3'd6,
    OUT_QUEUE_FULL    = 3'd7
  } outcome_t;

  typedef struct packed {
    logic               req_type;
    logic [ID_BITS-1:0] process_id;
    logic               requester_running;
  } req_t;

  typedef struct packed {
    outcome_t            outcome;
    logic [ID_BITS-1:0]  woken_id;
    logic [ID_BITS-1:0]  owner_id;
    logic                lock_open;
    logic [CNT_BITS-1:0] waiting_count;
  } result_t;

  // actions chosen for one request
  typedef struct packed {
    logic     push;
    logic     pop;
    logic     take;
    logic     release_lock;
    outcome_t outcome;
  } act_t;

endpackage

// ===== rtl/mwq_decide.sv =====
// ----------------------------------------------------------------------------
// mwq_decide
// Decides the outcome and the state actions of one lock or unlock request.
// ----------------------------------------------------------------------------
module mwq_decide import mwq_pkg::*; (
  input  req_t               req,
  input  logic               open_flag,
  input  logic [ID_BITS-1:0] holder,
  input  logic               full,
  input  logic               empty,
  output act_t               act
);

  always_comb begin
    act         = '0;
    act.outcome = OUT_NOT_RUNNING;
    if (req.req_type == REQ_LOCK) begin
      if (!req.requester_running) begin
        act.outcome = OUT_NOT_RUNNING;
      end else if (open_flag) begin
        act.take    = 1'b1;
        act.outcome = OUT_ACQUIRED;
      end else if (holder == req.process_id) begin
        act.outcome = OUT_ALREADY_OWNER;
      end else if (full) begin
        act.outcome = OUT_QUEUE_FULL;
      end else begin
        act.push    = 1'b1;
        act.outcome = OUT_QUEUED;
      end
    end else begin
      if (open_flag) begin
        act.outcome = OUT_ALREADY_OPEN;
      end else if (!empty) begin
        act.pop     = 1'b1;
        act.outcome = OUT_HANDED_OVER;
      end else begin
        act.release_lock = 1'b1;
        act.outcome      = OUT_OPENED;
      end
    end
  end

endmodule

// ===== rtl/mwq_fifo.sv =====
// ----------------------------------------------------------------------------
// mwq_fifo
// Register FIFO of waiting process ids with head and tail pointers and count.
// ----------------------------------------------------------------------------
module mwq_fifo import mwq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                pop,
  input  logic [ID_BITS-1:0]  push_id,
  output logic [ID_BITS-1:0]  head_id,
  output logic                full,
  output logic                empty,
  output logic [CNT_BITS-1:0] count_next
);

  logic [ID_BITS-1:0]  store [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] head_ptr;
  logic [PTR_BITS-1:0] tail_ptr;
  logic [CNT_BITS-1:0] count;
  logic [PTR_BITS-1:0] head_ptr_next;
  logic [PTR_BITS-1:0] tail_ptr_next;

  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(QUEUE_DEPTH);

  assign head_id = store[head_ptr];
  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);

  always_comb begin
    head_ptr_next = head_ptr;
    tail_ptr_next = tail_ptr;
    count_next    = count;
    if (push) begin
      tail_ptr_next = (tail_ptr == LAST_PTR) ? '0 : tail_ptr + 1'b1;
      count_next    = count + 1'b1;
    end else if (pop) begin
      head_ptr_next = (head_ptr == LAST_PTR) ? '0 : head_ptr + 1'b1;
      count_next    = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr <= '0;
      tail_ptr <= '0;
      count    <= '0;
    end else begin
      head_ptr <= head_ptr_next;
      tail_ptr <= tail_ptr_next;
      count    <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[tail_ptr] <= push_id;
    end
  end

  a_no_push_pop: assert property (@(posedge clk) disable iff (rst) !(push && pop))
    else $error("push and pop in the same cycle");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue count out of range");

endmodule

// ===== rtl/mutex_with_fifo_wait_queue_core.sv =====
// ----------------------------------------------------------------------------
// mutex_with_fifo_wait_queue_core
// Single mutex with a FIFO of waiting process ids; one result per request.
// ----------------------------------------------------------------------------
// pipeline: a taken request is captured in req_q and req_valid, from which
//   the result and done are registered
// throughput: one request per cycle, busy stays low; the FIFO push or pop and
//   the lock update commit at the same edge that registers the result
// reset: lock open, holder 0, queue empty; results are never stalled
module mutex_with_fifo_wait_queue_core import mwq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  req_t    req,
  output logic    done,
  output result_t result
);

  req_t               req_q;
  logic               req_valid;
  logic               open_flag;
  logic [ID_BITS-1:0] holder;
  logic               open_flag_next;
  logic [ID_BITS-1:0] holder_next;
  act_t               act;
  logic [ID_BITS-1:0] head_id;
  logic               full;
  logic               empty;
  logic [CNT_BITS-1:0] count_next;
  act_t               act_v;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
  end

  mwq_decide u_decide (
    .req       (req_q),
    .open_flag (open_flag),
    .holder    (holder),
    .full      (full),
    .empty     (empty),
    .act       (act)
  );

  // actions only count for a request that is really in the input register
  always_comb begin
    act_v = act;
    if (!req_valid) begin
      act_v.push         = 1'b0;
      act_v.pop          = 1'b0;
      act_v.take         = 1'b0;
      act_v.release_lock = 1'b0;
    end
  end

  mwq_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (act_v.push),
    .pop        (act_v.pop),
    .push_id    (req_q.process_id),
    .head_id    (head_id),
    .full       (full),
    .empty      (empty),
    .count_next (count_next)
  );

  always_comb begin
    open_flag_next = open_flag;
    holder_next    = holder;
    if (act_v.take) begin
      open_flag_next = 1'b0;
      holder_next    = req_q.process_id;
    end else if (act_v.pop) begin
      holder_next = head_id;
    end else if (act_v.release_lock) begin
      open_flag_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_flag <= 1'b1;
      holder    <= '0;
      done      <= 1'b0;
    end else begin
      open_flag <= open_flag_next;
      holder    <= holder_next;
      done      <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      result.outcome       <= act.outcome;
      result.woken_id      <= act.pop ? head_id : '0;
      result.owner_id      <= open_flag_next ? '0 : holder_next;
      result.lock_open     <= open_flag_next;
      result.waiting_count <= count_next;
    end
  end

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done == $past(req_valid))
    else $error("result strobe does not follow request");
  a_handover_closed: assert property (@(posedge clk) disable iff (rst)
    (done && result.outcome == OUT_HANDED_OVER) |-> !result.lock_open)
    else $error("lock open after handover");
  a_open_no_owner: assert property (@(posedge clk) disable iff (rst)
    (done && result.lock_open) |-> (result.owner_id == '0))
    else $error("owner reported on open lock");
  a_open_empty: assert property (@(posedge clk) disable iff (rst)
    open_flag |-> empty)
    else $error("waiters queued on open lock");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives lock and unlock requests into the mutex core and predicts each
// result with a model of the lock, its holder and the FIFO of waiters.
// A directed opening covers every outcome. Random bursts then follow with
// varied lock and unlock mixes, pid reuse and random idle gaps.
// ----------------------------------------------------------------------------
module testbench;
  import mwq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  class lock_outcome_tracker;
    logic               lock_free;
    logic [ID_BITS-1:0] holder_id;
    logic [ID_BITS-1:0] waiters[$];
    result_t            outcomes_due[$];
    int                 fails;

    function new();
      lock_free = 1'b1;
      holder_id = '0;
      fails     = 0;
    endfunction

    function int pending();
      return outcomes_due.size();
    endfunction

    // update the lock state for one accepted request and queue its result
    function void take_request(req_t r);
      result_t e;
      e = '0;
      if (r.req_type == REQ_LOCK) begin
        if (!r.requester_running) begin
          e.outcome = OUT_NOT_RUNNING;
        end else if (lock_free) begin
          lock_free = 1'b0;
          holder_id = r.process_id;
          e.outcome = OUT_ACQUIRED;
        end else if (holder_id == r.process_id) begin
          e.outcome = OUT_ALREADY_OWNER;
        end else if (waiters.size() >= QUEUE_DEPTH) begin
          e.outcome = OUT_QUEUE_FULL;
        end else begin
          waiters.push_back(r.process_id);
          e.outcome = OUT_QUEUED;
        end
      end else begin
        if (lock_free) begin
          e.outcome = OUT_ALREADY_OPEN;
        end else if (waiters.size() != 0) begin
          // ownership moves straight to the oldest waiter
          e.woken_id = waiters.pop_front();
          holder_id  = e.woken_id;
          e.outcome  = OUT_HANDED_OVER;
        end else begin
          lock_free = 1'b1;
          e.outcome = OUT_OPENED;
        end
      end
      e.owner_id      = lock_free ? '0 : holder_id;
      e.lock_open     = lock_free;
      e.waiting_count = CNT_BITS'(waiters.size());
      outcomes_due.push_back(e);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
        fails++;
      end
    endfunction

    function void match_result(result_t got);
      result_t e;
      if (outcomes_due.size() == 0) begin
        $error("result with no request pending: outcome %0d", got.outcome);
        fails++;
        return;
      end
      e = outcomes_due.pop_front();
      compare_field("outcome", 16'(e.outcome), 16'(got.outcome));
      compare_field("woken_id", 16'(e.woken_id), 16'(got.woken_id));
      compare_field("owner_id", 16'(e.owner_id), 16'(got.owner_id));
      compare_field("lock_open", 16'(e.lock_open), 16'(got.lock_open));
      compare_field("waiting_count", 16'(e.waiting_count), 16'(got.waiting_count));
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  req_t    req;
  logic    done;
  result_t result;

  lock_outcome_tracker tracker = new();

  mutex_with_fifo_wait_queue_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) tracker.take_request(req);
      if (done) tracker.match_result(result);
    end
  end

  function automatic req_t make_req(logic kind, logic [ID_BITS-1:0] pid, logic running);
    req_t r;
    r.req_type          = kind;
    r.process_id        = pid;
    r.requester_running = running;
    return r;
  endfunction

  // a few small pids come back often so the holder asks again now and then
  function automatic req_t random_req(int lock_pct);
    logic               kind;
    logic [ID_BITS-1:0] pid;
    logic               running;
    kind    = ($urandom_range(0, 99) < lock_pct) ? REQ_LOCK : REQ_UNLOCK;
    pid     = $urandom_range(0, 1) ? ID_BITS'($urandom_range(0, 3))
                                   : ID_BITS'($urandom_range(0, 255));
    running = ($urandom_range(0, 9) != 0);
    return make_req(kind, pid, running);
  endfunction

  task automatic send_request(input req_t r, input int max_gap);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int lock_pct;
    int max_gap;
    rst   <= 1'b1;
    start <= 1'b0;
    req   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: every outcome, pid extremes, queue filled to the limit
    send_request(make_req(REQ_UNLOCK, 8'd0, 1'b1), 0);
    send_request(make_req(REQ_LOCK, 8'd255, 1'b0), 0);
    send_request(make_req(REQ_LOCK, 8'd0, 1'b1), 0);
    send_request(make_req(REQ_LOCK, 8'd0, 1'b1), 0);
    send_request(make_req(REQ_UNLOCK, 8'd0, 1'b0), 0);
    send_request(make_req(REQ_LOCK, 8'd0, 1'b1), 0);
    send_request(make_req(REQ_LOCK, 8'd255, 1'b1), 0);
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      send_request(make_req(REQ_LOCK, ID_BITS'(i), 1'b1), 3);
    end
    send_request(make_req(REQ_LOCK, 8'd200, 1'b1), 0);
    // unlock from a process that does not hold the lock
    send_request(make_req(REQ_UNLOCK, 8'd77, 1'b1), 0);
    drain_results();

    for (int burst = 0; burst < 20; burst++) begin
      case ($urandom_range(0, 3))
        0: lock_pct = 35;
        1: lock_pct = 50;
        2: lock_pct = 65;
        default: lock_pct = 85;
      endcase
      max_gap = $urandom_range(0, 2) == 0 ? 0 : 12;
      for (int n = 0; n < 100; n++) begin
        send_request(random_req(lock_pct), max_gap);
      end
      if ($urandom_range(0, 1) == 1) drain_results();
    end

    drain_results();
    repeat (6) @(posedge clk);
    if (tracker.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== mutex_with_fifo_wait_queue_core.f =====
rtl/mwq_pkg.sv
rtl/mwq_decide.sv
rtl/mwq_fifo.sv
rtl/mutex_with_fifo_wait_queue_core.sv
tb/testbench.sv
